// ===== rtl/cdad_pkg.sv =====
// Shared types, constants and calendar helpers for the date advance block.
package cdad_pkg;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int IN_DAYS_W  = 16;
    localparam int CENT_W     = 8;
    localparam int YMOD_W     = 7;

    localparam logic [YEAR_W-1:0]  YEAR_LIMIT    = 14'd9999;
    localparam logic [YEAR_W-1:0]  DEFAULT_YEAR  = 14'd2000;
    localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC  = 5'd31;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN  = 5'd29;
    localparam logic [YMOD_W-1:0]  YMOD_LAST     = 7'd99;

    // Reciprocal of 100: q = (y * DIV100_MUL) >> DIV100_SHIFT, exact for y < 16384
    localparam logic [12:0]        DIV100_MUL    = 13'd5243;
    localparam int                 DIV100_SHIFT  = 19;
    localparam int                 PROD_W        = YEAR_W + 13;
    localparam logic [CENT_W-1:0]  CENT_SCALE    = 8'd100;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [YEAR_W-1:0]  year_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div;
        logic prep;
        logic step;
        logic out;
    } cdad_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic walk_last;
    } cdad_status_t;

    // Length of a month; months outside 1..12 report 31
    function automatic day_t days_in_month(input month_t m, input logic leap);
        month_t idx;
        day_t   len;
        idx = m - MONTH_FIRST;
        if ((m < MONTH_FIRST) || (m > MONTH_LAST))
        begin
            len = DAY_LAST_DEC;
        end
        else if ((m == MONTH_FEB) && leap)
        begin
            len = FEB_LEAP_LEN;
        end
        else
        begin
            len = MONTH_LEN[idx];
        end
        return len;
    endfunction

endpackage

// ===== rtl/cdad_ctrl.sv =====
// Controller state machine: sequences load, split, check, month walk and hand-off.
module cdad_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  cdad_pkg::cdad_status_t status,
    output cdad_pkg::cdad_cmd_t   cmd
);
    import cdad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Decode state into datapath commands and pick the next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.out    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set output valid on hand-off, drop it once the item is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/cdad_datapath.sv =====
// Datapath: start date check, year split by 100, one-month-per-cycle walk, result register.
module cdad_datapath #(
    parameter int DAYS_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdad_pkg::cdad_cmd_t    cmd,
    output cdad_pkg::cdad_status_t status,
    input  logic [cdad_pkg::DAY_W-1:0]     start_day,
    input  logic [cdad_pkg::MONTH_W-1:0]   start_month,
    input  logic [cdad_pkg::YEAR_W-1:0]    start_year,
    input  logic [cdad_pkg::IN_DAYS_W-1:0] days_to_add,
    output logic [cdad_pkg::DAY_W-1:0]     result_day,
    output logic [cdad_pkg::MONTH_W-1:0]   result_month,
    output logic [cdad_pkg::YEAR_W-1:0]    result_year,
    output logic                           start_was_valid,
    output logic                           year_overflow
);
    import cdad_pkg::*;

    logic [DAYS_WIDTH-1:0] days_load;

    // Keep only the low DAYS_WIDTH bits of the count, or zero-extend it when DAYS_WIDTH is wider
    generate
        if (DAYS_WIDTH <= IN_DAYS_W)
        begin : g_trunc
            assign days_load = days_to_add[DAYS_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign days_load = {{(DAYS_WIDTH-IN_DAYS_W){1'b0}}, days_to_add};
        end
    endgenerate

    day_t                  in_day_reg;
    month_t                in_mon_reg;
    year_t                 in_year_reg;
    logic [CENT_W-1:0]     cent_reg;
    logic [DAYS_WIDTH-1:0] left_reg;
    logic [DAYS_WIDTH-1:0] left_next;
    day_t                  day_reg;
    day_t                  day_next;
    month_t                mon_reg;
    month_t                mon_next;
    year_t                 year_reg;
    year_t                 year_next;
    logic [YMOD_W-1:0]     ymod_reg;
    logic [YMOD_W-1:0]     ymod_next;
    logic [1:0]            cmod_reg;
    logic [1:0]            cmod_next;
    logic                  valid_reg;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  walk_last;

    day_t                  res_day_reg;
    month_t                res_mon_reg;
    year_t                 res_year_reg;
    logic                  res_valid_reg;
    logic                  res_ovf_reg;

    // Split the start year into century and year-in-century
    logic [PROD_W-1:0]     div_prod;
    logic [CENT_W-1:0]     cent_q;
    logic [YEAR_W-1:0]     cent_scaled;
    logic [YEAR_W-1:0]     ymod_wide;
    logic [YMOD_W-1:0]     start_ymod;
    logic                  start_leap;
    logic                  start_ok;

    assign div_prod    = PROD_W'(in_year_reg) * PROD_W'(DIV100_MUL);
    assign cent_q      = div_prod[DIV100_SHIFT +: CENT_W];
    assign cent_scaled = YEAR_W'(cent_reg) * YEAR_W'(CENT_SCALE);
    assign ymod_wide   = in_year_reg - cent_scaled;
    assign start_ymod  = ymod_wide[YMOD_W-1:0];
    assign start_leap  = ((in_year_reg[1:0] == 2'd0) && (start_ymod != '0))
                      || ((start_ymod == '0) && (cent_reg[1:0] == 2'd0));

    // Check the start date
    always_comb
    begin
        start_ok = (in_year_reg != '0) && (in_year_reg <= YEAR_LIMIT)
                && (in_mon_reg >= MONTH_FIRST) && (in_mon_reg <= MONTH_LAST)
                && (in_day_reg != '0)
                && (in_day_reg <= days_in_month(in_mon_reg, start_leap));
    end

    // One month step of the walk
    logic    leap;
    day_t    dim;
    day_t    rest;
    logic    fits;

    assign leap = ((year_reg[1:0] == 2'd0) && (ymod_reg != '0))
               || ((ymod_reg == '0) && (cmod_reg == 2'd0));
    assign dim  = days_in_month(mon_reg, leap);
    assign rest = dim - day_reg;
    assign fits = (left_reg <= DAYS_WIDTH'(rest));

    always_comb
    begin
        left_next = left_reg;
        day_next  = day_reg;
        mon_next  = mon_reg;
        year_next = year_reg;
        ymod_next = ymod_reg;
        cmod_next = cmod_reg;
        ovf_next  = ovf_reg;
        walk_last = 1'b0;
        if (left_reg == '0)
        begin
            walk_last = 1'b1;
        end
        else if (fits)
        begin
            day_next  = day_reg + DAY_W'(left_reg);
            left_next = '0;
            walk_last = 1'b1;
        end
        else
        begin
            left_next = left_reg - DAYS_WIDTH'(rest) - DAYS_WIDTH'(1);
            day_next  = DAY_FIRST;
            if (mon_reg == MONTH_LAST)
            begin
                if (year_reg == YEAR_LIMIT)
                begin
                    // Saturate past the four-digit year
                    day_next  = DAY_LAST_DEC;
                    mon_next  = MONTH_LAST;
                    ovf_next  = 1'b1;
                    left_next = '0;
                    walk_last = 1'b1;
                end
                else
                begin
                    mon_next  = MONTH_FIRST;
                    year_next = year_reg + YEAR_W'(1);
                    if (ymod_reg == YMOD_LAST)
                    begin
                        ymod_next = '0;
                        cmod_next = cmod_reg + 2'd1;
                    end
                    else
                    begin
                        ymod_next = ymod_reg + YMOD_W'(1);
                    end
                end
            end
            else
            begin
                mon_next = mon_reg + MONTH_W'(1);
            end
        end
    end

    assign status.walk_last = walk_last;

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_day_reg  <= start_day;
            in_mon_reg  <= start_month;
            in_year_reg <= start_year;
            left_reg    <= days_load;
        end
        else if (cmd.step)
        begin
            left_reg <= left_next;
        end

        if (cmd.div)
        begin
            cent_reg <= cent_q;
        end

        if (cmd.prep)
        begin
            valid_reg <= start_ok;
            ovf_reg   <= 1'b0;
            if (start_ok)
            begin
                day_reg  <= in_day_reg;
                mon_reg  <= in_mon_reg;
                year_reg <= in_year_reg;
                ymod_reg <= start_ymod;
                cmod_reg <= cent_reg[1:0];
            end
            else
            begin
                // Fall back to 1/1/2000: year-in-century 0, century 20
                day_reg  <= DAY_FIRST;
                mon_reg  <= MONTH_FIRST;
                year_reg <= DEFAULT_YEAR;
                ymod_reg <= '0;
                cmod_reg <= 2'd0;
            end
        end
        else if (cmd.step)
        begin
            day_reg  <= day_next;
            mon_reg  <= mon_next;
            year_reg <= year_next;
            ymod_reg <= ymod_next;
            cmod_reg <= cmod_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Result register, loaded at hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
        end
        else if (cmd.out)
        begin
            res_valid_reg <= valid_reg;
            res_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out)
        begin
            res_day_reg  <= day_reg;
            res_mon_reg  <= mon_reg;
            res_year_reg <= year_reg;
        end
    end

    assign result_day      = res_day_reg;
    assign result_month    = res_mon_reg;
    assign result_year     = res_year_reg;
    assign start_was_valid = res_valid_reg;
    assign year_overflow   = res_ovf_reg;

endmodule

// ===== rtl/calendar_date_add_days.sv =====
// Top level: Gregorian date advance by a day count with invalid-start and year-9999 handling.
// Each item is loaded, its year split by 100 and its start date checked, then walked one month per
// cycle until the count is used up or the date saturates at year 9999, then handed to the output.
// The largest 16-bit count crosses about 2150 months.
// The block takes one item at a time; the next item is taken once the result is loaded into
// the output register, which waits while an earlier result is still stalled there.
module calendar_date_add_days #(
    parameter int DAYS_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cdad_pkg::DAY_W-1:0]     start_day,
    input  logic [cdad_pkg::MONTH_W-1:0]   start_month,
    input  logic [cdad_pkg::YEAR_W-1:0]    start_year,
    input  logic [cdad_pkg::IN_DAYS_W-1:0] days_to_add,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cdad_pkg::DAY_W-1:0]     result_day,
    output logic [cdad_pkg::MONTH_W-1:0]   result_month,
    output logic [cdad_pkg::YEAR_W-1:0]    result_year,
    output logic                           start_was_valid,
    output logic                           year_overflow
);
    import cdad_pkg::*;

    // Reset (rst_n, asynchronous, active low) returns the controller to idle and clears out_valid.
    cdad_cmd_t    cmd;
    cdad_status_t status;

    // Sequence the item through its steps
    cdad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the date and walk it month by month
    cdad_datapath #(
        .DAYS_WIDTH (DAYS_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .start_day       (start_day),
        .start_month     (start_month),
        .start_year      (start_year),
        .days_to_add     (days_to_add),
        .result_day      (result_day),
        .result_month    (result_month),
        .result_year     (result_year),
        .start_was_valid (start_was_valid),
        .year_overflow   (year_overflow)
    );

endmodule
